// ===== sv/window_mean_percentile95_macros.svh =====
// Assertion macros for the window mean / percentile block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef WINDOW_MEAN_PERCENTILE95_MACROS_SVH
`define WINDOW_MEAN_PERCENTILE95_MACROS_SVH

// Check a consequence in the same cycle
`define WMP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the next cycle
`define WMP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/wmp_pkg.sv =====
// Shared constants and controller/datapath command types.
// No dependencies.
`default_nettype none
package wmp_pkg;
	localparam int DEPTH       = 128;
	localparam int AW          = $clog2(DEPTH);
	localparam int SW          = 16;
	localparam int TW          = 23;
	localparam int LW          = 7;
	localparam int DW          = 7;
	localparam logic [LW-1:0] LIMIT_RESET = 7'd120;
	localparam int PCT_NUM     = 95;
	localparam int PCT_DEN     = 100;
	// Divide by 100 as a multiply by ceil(2^30 / 100) and a 30-bit shift;
	// the floor is exact for every dividend below 2^23
	localparam int RW          = 24;
	localparam int RCP_SH      = 30;
	localparam logic [RW-1:0] RCP_MUL = 24'd10737419;

	typedef struct packed {
		logic load_sample;
		logic ev_read;
		logic ev_take;
		logic ins_start;
		logic scan_rd;
		logic ins_tail;
		logic div_lo;
		logic div_mean;
		logic div_pct;
		logic cap_lo;
		logic cap_mean;
		logic cap_pct;
		logic rd_a;
		logic rd_b;
		logic cap_a;
		logic cap_b;
		logic push;
	} cmd_t;

	typedef struct packed {
		logic sample_zero;
		logic evict_need;
		logic fill_zero;
		logic scan_last;
		logic div_done;
		logic out_full;
	} st_t;
endpackage
`default_nettype wire

// ===== sv/wmp_in_if.sv =====
// Input channel: one frame-rate sample per request.
// Depends on wmp_pkg.
`default_nettype none
interface wmp_in_if;
	logic                   valid;
	logic                   ready;
	logic [wmp_pkg::SW-1:0] fps_sample;
	modport source (output valid, output fps_sample, input ready);
	modport sink (input valid, input fps_sample, output ready);
endinterface
`default_nettype wire

// ===== sv/wmp_out_if.sv =====
// Output channel: mean, percentile and sample count per request.
// Depends on wmp_pkg.
`default_nettype none
interface wmp_out_if;
	logic                   valid;
	logic                   ready;
	logic [wmp_pkg::SW-1:0] window_mean;
	logic [wmp_pkg::SW-1:0] percentile_95;
	logic [wmp_pkg::LW-1:0] samples_held;
	modport source (output valid, output window_mean, output percentile_95,
		output samples_held, input ready);
	modport sink (input valid, input window_mean, input percentile_95,
		input samples_held, output ready);
endinterface
`default_nettype wire

// ===== sv/wmp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module wmp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule
`default_nettype wire

// ===== sv/wmp_div.sv =====
// Restoring divider, one quotient bit per cycle, small divisor.
// Depends on wmp_pkg.
`default_nettype none
module wmp_div (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [wmp_pkg::TW-1:0] dividend,
	input  wire logic [wmp_pkg::DW-1:0] divisor,
	output logic                        done,
	output logic      [wmp_pkg::TW-1:0] quotient
);
	import wmp_pkg::*;

	localparam int CW = $clog2(TW);

	logic [TW-1:0] sh_q;
	logic [DW-1:0] r_q;
	logic [DW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	assign trial = {r_q, sh_q[TW-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	// Shift in one dividend bit, subtract when it fits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(TW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= dividend;
			r_q   <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			r_q  <= ge ? diff[DW-1:0] : trial[DW-1:0];
			sh_q <= {sh_q[TW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = sh_q;
endmodule
`default_nettype wire

// ===== sv/wmp_dp.sv =====
// Datapath: sample ring, sorted store, window counters, mean divider,
// divide-by-100 multiply and result register. Depends on wmp_pkg, wmp_ram, wmp_div.
`default_nettype none
module wmp_dp (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire wmp_pkg::cmd_t          cmd,
	output wmp_pkg::st_t                st,
	input  wire logic                   limit_we,
	input  wire logic [wmp_pkg::LW-1:0] limit_wdata,
	input  wire logic [wmp_pkg::SW-1:0] in_sample,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic      [wmp_pkg::SW-1:0] out_mean,
	output logic      [wmp_pkg::SW-1:0] out_pct,
	output logic      [wmp_pkg::LW-1:0] out_held
);
	import wmp_pkg::*;

	localparam int SCW = $clog2(PCT_NUM * (DEPTH - 1) + 1);
	localparam int PW  = TW + RW;

	logic [LW-1:0] limit_q;
	logic [LW-1:0] lim_eff;
	logic [AW-1:0] fill_q;
	logic [AW-1:0] wslot_q;
	logic [TW-1:0] total_q;
	logic [SW-1:0] sample_q;
	logic [SW-1:0] ev_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] scan_n_q;
	logic          mode_ins_q;
	logic          found_q;
	logic          vld_s1;
	logic [AW-1:0] addr_s1;
	logic [AW-1:0] lo_q;
	logic [DW-1:0] r100_q;
	logic [SW-1:0] a_q;
	logic [TW-1:0] prod_q;
	logic [SW-1:0] mean_q;
	logic [PW-1:0] rcp_q;

	logic [SW-1:0] ring_rd;
	logic [SW-1:0] s_rd;
	logic          s_we;
	logic [AW-1:0] s_wa;
	logic [SW-1:0] s_wd;
	logic          s_re;
	logic [AW-1:0] s_ra;
	logic [AW-1:0] oldest;
	logic [SCW-1:0] scaled;
	logic [SW-1:0] diff;
	logic [TW-1:0] rcp_in;
	logic [SW-1:0] rcp_quo;

	logic          div_start;
	logic [TW-1:0] div_dvd;
	logic [DW-1:0] div_dvs;
	logic          div_done;
	logic [TW-1:0] div_quo;

	assign lim_eff = (limit_q == '0) ? LW'(1) : limit_q;
	assign oldest  = wslot_q - fill_q;
	assign scaled  = SCW'(fill_q - 1'b1) * SCW'(PCT_NUM);
	assign diff    = s_rd - a_q;
	assign rcp_in  = cmd.div_pct ? prod_q : TW'(scaled);
	assign rcp_quo = rcp_q[RCP_SH +: SW];

	// Hold the window limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (limit_we) begin
			limit_q <= limit_wdata;
		end
	end

	// Advance window counters and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			wslot_q    <= '0;
			total_q    <= '0;
			vld_s1     <= 1'b0;
			found_q    <= 1'b0;
			mode_ins_q <= 1'b0;
			idx_q      <= '0;
			scan_n_q   <= '0;
		end else begin
			vld_s1 <= cmd.scan_rd;
			if (cmd.ev_take) begin
				total_q    <= total_q - TW'(ring_rd);
				scan_n_q   <= fill_q;
				fill_q     <= fill_q - 1'b1;
				idx_q      <= '0;
				found_q    <= 1'b0;
				mode_ins_q <= 1'b0;
			end else if (cmd.ins_start) begin
				total_q    <= total_q + TW'(sample_q);
				wslot_q    <= wslot_q + 1'b1;
				scan_n_q   <= fill_q;
				fill_q     <= fill_q + 1'b1;
				idx_q      <= fill_q - 1'b1;
				found_q    <= 1'b0;
				mode_ins_q <= 1'b1;
			end else begin
				if (cmd.scan_rd) begin
					idx_q <= mode_ins_q ? idx_q - 1'b1 : idx_q + 1'b1;
				end
				if (vld_s1 && !found_q) begin
					if (mode_ins_q) begin
						found_q <= !(s_rd > sample_q);
					end else begin
						found_q <= (s_rd == ev_q);
					end
				end
			end
		end
	end

	// Capture payload values
	always_ff @(posedge clk) begin
		if (cmd.load_sample) begin
			sample_q <= in_sample;
		end
		if (cmd.ev_take) begin
			ev_q <= ring_rd;
		end
		if (cmd.scan_rd) begin
			addr_s1 <= idx_q;
		end
		// Divide the rank or the interpolation product by 100
		if (cmd.div_lo || cmd.div_pct) begin
			rcp_q <= PW'(rcp_in) * PW'(RCP_MUL);
		end
		if (cmd.cap_lo) begin
			lo_q   <= rcp_quo[AW-1:0];
			r100_q <= DW'(scaled - SCW'(rcp_quo) * SCW'(PCT_DEN));
		end
		if (cmd.cap_a) begin
			a_q <= s_rd;
		end
		// A zero fraction ignores the upper neighbor, which may be unwritten
		if (cmd.cap_b) begin
			prod_q <= (r100_q == '0) ? '0 : TW'(diff) * TW'(r100_q);
		end
		if (cmd.cap_mean) begin
			mean_q <= div_quo[SW-1:0];
		end
	end

	// Shift entries during scans, drop or place the value
	always_comb begin
		s_we = 1'b0;
		s_wa = '0;
		s_wd = '0;
		if (vld_s1) begin
			if (mode_ins_q) begin
				if (!found_q) begin
					s_we = 1'b1;
					s_wa = addr_s1 + 1'b1;
					s_wd = (s_rd > sample_q) ? s_rd : sample_q;
				end
			end else if (found_q) begin
				s_we = 1'b1;
				s_wa = addr_s1 - 1'b1;
				s_wd = s_rd;
			end
		end
		if (cmd.ins_tail && !found_q) begin
			s_we = 1'b1;
			s_wa = '0;
			s_wd = sample_q;
		end
	end

	// Select the sorted store read address
	always_comb begin
		s_re = cmd.scan_rd | cmd.rd_a | cmd.rd_b;
		if (cmd.rd_a) begin
			s_ra = lo_q;
		end else if (cmd.rd_b) begin
			s_ra = lo_q + 1'b1;
		end else begin
			s_ra = idx_q;
		end
	end

	// Start the mean division
	assign div_start = cmd.div_mean;
	assign div_dvd   = total_q;
	assign div_dvs   = DW'(fill_q);

	wmp_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_ring (
		.clk     (clk),
		.wr_en   (cmd.ins_start),
		.wr_addr (wslot_q),
		.wr_data (sample_q),
		.rd_en   (cmd.ev_read),
		.rd_addr (oldest),
		.rd_data (ring_rd)
	);

	wmp_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_sorted (
		.clk     (clk),
		.wr_en   (s_we),
		.wr_addr (s_wa),
		.wr_data (s_wd),
		.rd_en   (s_re),
		.rd_addr (s_ra),
		.rd_data (s_rd)
	);

	wmp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.done      (div_done),
		.quotient  (div_quo)
	);

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.cap_pct) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_pct) begin
			out_mean <= mean_q;
			out_pct  <= a_q + rcp_quo;
			out_held <= LW'(fill_q);
		end
	end

	assign st.sample_zero = (in_sample == '0);
	assign st.evict_need  = (LW'(fill_q) >= lim_eff);
	assign st.fill_zero   = (fill_q == '0);
	assign st.scan_last   = mode_ins_q ? (idx_q == '0) : (idx_q == scan_n_q - 1'b1);
	assign st.div_done    = div_done;
	assign st.out_full    = out_valid;
endmodule
`default_nettype wire

// ===== sv/wmp_ctrl.sv =====
// Controller state machine: sequences eviction, sorted insertion,
// percentile and mean divisions. Depends on wmp_pkg.
`default_nettype none
module wmp_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire wmp_pkg::st_t st,
	output wmp_pkg::cmd_t     cmd
);
	import wmp_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_CHECK, S_EV_TAKE, S_EV_SCAN, S_EV_FLUSH,
		S_INS_SCAN, S_INS_FLUSH, S_INS_TAIL, S_LO_GO, S_LO_WAIT,
		S_RD_A, S_RD_B, S_RD_C, S_MEAN_GO, S_MEAN_WAIT,
		S_PCT_WAIT
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// Decode commands from the current state
	always_comb begin
		cmd             = '0;
		cmd.load_sample = accept && !st.sample_zero;
		case (state_q)
			S_CHECK: begin
				cmd.ev_read   = st.evict_need;
				cmd.ins_start = !st.evict_need;
			end
			S_EV_TAKE:   cmd.ev_take = 1'b1;
			S_EV_SCAN:   cmd.scan_rd = 1'b1;
			S_INS_SCAN:  cmd.scan_rd = 1'b1;
			S_INS_TAIL:  cmd.ins_tail = 1'b1;
			S_LO_GO:     cmd.div_lo = 1'b1;
			S_LO_WAIT:   cmd.cap_lo = 1'b1;
			S_RD_A:      cmd.rd_a = 1'b1;
			S_RD_B: begin
				cmd.rd_b  = 1'b1;
				cmd.cap_a = 1'b1;
			end
			S_RD_C:      cmd.cap_b = 1'b1;
			S_MEAN_GO:   cmd.div_mean = 1'b1;
			S_MEAN_WAIT: begin
				cmd.cap_mean = st.div_done;
				cmd.div_pct  = st.div_done;
			end
			// Hold the finished result until the output register frees
			S_PCT_WAIT: begin
				cmd.cap_pct = !st.out_full;
				cmd.push    = cmd.cap_pct;
			end
			default: ;
		endcase
	end

	// Advance the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && !st.sample_zero) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (st.evict_need) begin
						state_q <= S_EV_TAKE;
					end else if (st.fill_zero) begin
						state_q <= S_INS_TAIL;
					end else begin
						state_q <= S_INS_SCAN;
					end
				end
				S_EV_TAKE:   state_q <= S_EV_SCAN;
				S_EV_SCAN: begin
					if (st.scan_last) begin
						state_q <= S_EV_FLUSH;
					end
				end
				S_EV_FLUSH:  state_q <= S_CHECK;
				S_INS_SCAN: begin
					if (st.scan_last) begin
						state_q <= S_INS_FLUSH;
					end
				end
				S_INS_FLUSH: state_q <= S_INS_TAIL;
				S_INS_TAIL:  state_q <= S_LO_GO;
				S_LO_GO:     state_q <= S_LO_WAIT;
				S_LO_WAIT:   state_q <= S_RD_A;
				S_RD_A:      state_q <= S_RD_B;
				S_RD_B:      state_q <= S_RD_C;
				S_RD_C:      state_q <= S_MEAN_GO;
				S_MEAN_GO:   state_q <= S_MEAN_WAIT;
				S_MEAN_WAIT: begin
					if (st.div_done) begin
						state_q <= S_PCT_WAIT;
					end
				end
				S_PCT_WAIT: begin
					if (cmd.push) begin
						state_q <= S_IDLE;
					end
				end
				default:     state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== sv/window_mean_percentile95.sv =====
// Sliding-window mean and interpolated 95th percentile of frame-rate samples.
// Channels: in_ch carries one Q12.4 sample per request; a zero sample is
// taken and dropped at once, with no result. out_ch carries one result per
// nonzero sample: truncated window mean, 95th percentile, samples held.
// The user must have window_limit written through window_limit_we only while
// the block is idle; the block itself does not enforce this.
// The sorted-store read/shift passes (one entry per cycle) and the
// one-bit-per-cycle mean divider take most of the time per sample; both
// divisions by 100 take one reciprocal multiply. One sample is worked at a
// time; the next request is taken in the cycle after a result is posted.
// The result waits in an output register; while it waits the block takes and
// works the next sample, then holds in_ch.ready low until the register frees.
// Reset empties the window and sets the limit to 120; no clearing pass.
// Depends on wmp_pkg, wmp_in_if, wmp_out_if, wmp_ctrl, wmp_dp and the macros.
`default_nettype none
`include "window_mean_percentile95_macros.svh"
module window_mean_percentile95 (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	wmp_in_if.sink                      in_ch,
	wmp_out_if.source                   out_ch,
	input  wire logic                   window_limit_we,
	input  wire logic [wmp_pkg::LW-1:0] window_limit
);
	import wmp_pkg::*;

	cmd_t cmd;
	st_t  st;
	logic zero_req;

	assign zero_req = in_ch.valid && in_ch.ready && (in_ch.fps_sample == '0);

	wmp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.st       (st),
		.cmd      (cmd)
	);

	wmp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.limit_we    (window_limit_we),
		.limit_wdata (window_limit),
		.in_sample   (in_ch.fps_sample),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.out_mean    (out_ch.window_mean),
		.out_pct     (out_ch.percentile_95),
		.out_held    (out_ch.samples_held)
	);

	// A dropped zero sample leaves the input open
	`WMP_ASSERT_NEXT(a_zero_drop, zero_req, in_ch.ready, "zero sample not dropped")
	// A result never overwrites one still waiting
	`WMP_ASSERT_NOW(a_no_overrun, cmd.push, !st.out_full, "result register overrun")
	// A result always reports a nonempty window
	`WMP_ASSERT_NOW(a_held_nonzero, out_ch.valid, out_ch.samples_held != '0, "empty window reported")
endmodule
`default_nettype wire
